[hw/rtl/wsfr_pkg.sv]
// Shared types and constants of the websocket frame receiver.
// The front, the command queue, the back and the top level all use this package.
// It has no dependencies of its own.
package wsfr_pkg;

    // Result kinds, carried on the output tuser
    localparam logic [2:0] K_APP   = 3'd0;
    localparam logic [2:0] K_REPLY = 3'd1;
    localparam logic [2:0] K_DONE  = 3'd2;
    localparam logic [2:0] K_PING  = 3'd3;
    localparam logic [2:0] K_PONG  = 3'd4;
    localparam logic [2:0] K_CLOSE = 3'd5;

    // Field widths and sizes
    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int OPC_W       = 4;
    localparam int FRAME_LEN_W = 63;
    // Reply header: opcode byte, length byte and up to 8 extended length bytes
    localparam int REP_MAX     = 10;
    localparam int REP_CNT_W   = 4;
    // Payload bits on the output tdata, padded to whole bytes
    localparam int OUT_DATA_W  = 80;

    // Defaults for the top level parameters
    localparam int DEF_LENGTH_BITS = 64;
    localparam int DEF_QUEUE_DEPTH = 4;

    // One command from the front: everything one input beat gives rise to
    typedef struct packed {
        logic [OPC_W-1:0]                  opcode;
        logic [REP_CNT_W-1:0]              rep_cnt;
        logic [REP_MAX-1:0][BYTE_W-1:0]    rep;
        logic                              has_byte;
        logic [KIND_W-1:0]                 byte_kind;
        logic [BYTE_W-1:0]                 pay_byte;
        logic                              ev_valid;
        logic [KIND_W-1:0]                 ev_kind;
        logic [FRAME_LEN_W-1:0]            length;
    } t_cmd;

endpackage

[hw/rtl/websocket_frame_receiver_unit.sv]
// Receive-side websocket frame deframer, top level.
// Uses wsfr_pkg, wsfr_front, wsfr_queue and wsfr_back.
//
// Usage:
//   The slave channel takes the received stream one byte per beat. The master
//   channel gives result beats: tuser holds the kind (application payload, reply
//   byte, frame done, ping, pong, close request), tdata the byte, the frame
//   opcode and the decoded length, and tlast marks the final result of one
//   input byte. A header byte that completes nothing gives no result.
//   Throughput: one input byte per cycle while the command queue is not full.
//   The back part emits one result per cycle while the master side is ready; a
//   payload byte that ends a data, ping or close frame gives two results and a
//   completed ping or close header up to eleven, so such beats hold the back part
//   until all their results are out while the command queue keeps taking bytes.
//   A byte's first result goes through the queue write, then the output register.
//   Reset (synchronous, active low) returns to waiting for a header and empties
//   the queue and the output register.
//   Stall: when the master side holds tready low, the output beat is held, the
//   back part stops, and once the queue is full tready on the slave side drops.
module websocket_frame_receiver_unit #(
    parameter int LENGTH_BITS = wsfr_pkg::DEF_LENGTH_BITS,
    parameter int QUEUE_DEPTH = wsfr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte, [11:8] frame_opcode, [74:12] frame_length, [79:75] zero
    output logic [wsfr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast    // last
);

    localparam int PAD_W = wsfr_pkg::OUT_DATA_W - wsfr_pkg::FRAME_LEN_W
                           - wsfr_pkg::OPC_W - wsfr_pkg::BYTE_W;

    wsfr_pkg::t_cmd                     push_cmd, head_cmd;
    logic                               push, full, head_valid, pop;
    logic [wsfr_pkg::BYTE_W-1:0]        out_byte;
    logic [wsfr_pkg::OPC_W-1:0]         out_opcode;
    logic [wsfr_pkg::FRAME_LEN_W-1:0]   out_length;

    // Accept and classify bytes
    wsfr_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_queue_full (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Decouple front and back
    wsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    // Expand commands into result beats
    wsfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_kind      (o_m_axis_tuser),
        .o_byte      (out_byte),
        .o_opcode    (out_opcode),
        .o_length    (out_length),
        .o_last      (o_m_axis_tlast)
    );

    // Pack the result fields, lowest first
    assign o_m_axis_tdata = {{PAD_W{1'b0}}, out_length, out_opcode, out_byte};

endmodule

[hw/rtl/wsfr_front.sv]
// Front part of the websocket frame receiver: takes stream bytes, collects headers,
// tracks the payload and turns each byte that gives a result into one command for
// the back part. Depends on wsfr_pkg.
module wsfr_front #(
    parameter int LENGTH_BITS = wsfr_pkg::DEF_LENGTH_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_queue_full,
    output logic                o_push,
    output wsfr_pkg::t_cmd      o_cmd
);

    localparam int LW = wsfr_pkg::FRAME_LEN_W;

    // Phase codes
    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Opcodes and header bit fields
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'ha;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [3:0] STORE_FULL = 4'd14;
    localparam int         STORE_KEEP = wsfr_pkg::REP_MAX;

    // End-of-frame event for an opcode
    function automatic logic [3:0] finish_event(input logic [3:0] op);
        logic [3:0] ev;
        ev = {1'b0, wsfr_pkg::K_APP};
        if (op <= 4'd2) begin
            ev = {1'b1, wsfr_pkg::K_DONE};
        end else if (op == OPC_PING) begin
            ev = {1'b1, wsfr_pkg::K_PING};
        end else if (op == OPC_PONG) begin
            ev = {1'b1, wsfr_pkg::K_PONG};
        end else if (op == OPC_CLOSE) begin
            ev = {1'b1, wsfr_pkg::K_CLOSE};
        end
        return ev;
    endfunction

    logic [1:0]             r_phase, n_phase;
    logic [3:0]             r_count, n_count;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [LW-1:0]          r_total, n_total;
    logic [3:0]             r_op, n_op;
    // Only the first ten header bytes are kept; later mask bytes are counted only
    logic [7:0]             r_store [0:STORE_KEEP-1];

    logic                   accept;
    logic                   in_payload;
    logic [3:0]             idx;
    logic [3:0]             cnt_new;
    logic [7:0]             v [0:STORE_KEEP-1];
    logic [3:0]             ext;
    logic [3:0]             need;
    logic                   hdr_done;
    logic [63:0]            len64;
    logic [LENGTH_BITS-1:0] len_keep;
    logic [3:0]             new_op;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [3:0]             ev;
    wsfr_pkg::t_cmd         cmd;

    assign o_ready    = !i_queue_full;
    assign accept     = i_valid && o_ready;
    assign in_payload = (r_phase == PH_PAYLOAD);

    // Restart header collection outside a header or on overrun
    assign idx     = (r_phase != PH_HEADER || r_count >= STORE_FULL) ? 4'd0 : r_count;
    assign cnt_new = idx + 4'd1;

    // View of the stored header with the current byte in place
    always_comb begin
        for (int k = 0; k < STORE_KEEP; k++) begin
            v[k] = (idx == 4'(k)) ? i_byte : r_store[k];
        end
    end

    // Decode extended length count and header size
    always_comb begin
        case (v[1][6:0])
            LEN_EXT16: ext = 4'd2;
            LEN_EXT64: ext = 4'd8;
            default:   ext = 4'd0;
        endcase
        need     = 4'd2 + ext + (v[1][7] ? 4'd4 : 4'd0);
        hdr_done = (cnt_new >= 4'd2) && (cnt_new == need);
    end

    // Assemble the decoded length; top bit of the long form is dropped
    always_comb begin
        case (ext)
            4'd2:    len64 = {48'd0, v[2], v[3]};
            4'd8:    len64 = {1'b0, v[2][6:0], v[3], v[4], v[5], v[6], v[7], v[8], v[9]};
            default: len64 = {57'd0, v[1][6:0]};
        endcase
        len_keep = len64[LENGTH_BITS-1:0];
        new_op   = v[0][3:0];
    end

    assign left_dec = (r_left != '0) ? r_left - 1'b1 : r_left;

    // Classify the byte and build its command
    always_comb begin
        cmd     = '0;
        n_phase = r_phase;
        n_count = r_count;
        n_left  = r_left;
        n_total = r_total;
        n_op    = r_op;
        ev      = '0;
        if (in_payload) begin
            cmd.opcode   = r_op;
            cmd.pay_byte = i_byte;
            if (r_op <= 4'd2) begin
                cmd.has_byte  = 1'b1;
                cmd.byte_kind = wsfr_pkg::K_APP;
            end else if (r_op == OPC_PING || r_op == OPC_CLOSE) begin
                cmd.has_byte  = 1'b1;
                cmd.byte_kind = wsfr_pkg::K_REPLY;
            end
            n_left = left_dec;
            if (left_dec == '0) begin
                ev      = finish_event(r_op);
                n_phase = PH_WAIT;
                n_count = 4'd0;
                if (ev[2:0] == wsfr_pkg::K_DONE) begin
                    cmd.length = r_total;
                end
            end
        end else begin
            n_phase = PH_HEADER;
            n_count = cnt_new;
            if (hdr_done) begin
                cmd.opcode = new_op;
                n_op       = new_op;
                n_total    = LW'(len_keep);
                n_left     = len_keep;
                n_phase    = PH_PAYLOAD;
                // Echo the header for ping (as pong) and close
                if (new_op == OPC_PING || new_op == OPC_CLOSE) begin
                    cmd.rep_cnt = 4'd2 + ext;
                    cmd.rep[0]  = (new_op == OPC_PING) ? {v[0][7:4], OPC_PONG} : v[0];
                    cmd.rep[1]  = {1'b0, v[1][6:0]};
                    for (int k = 2; k < STORE_KEEP; k++) begin
                        cmd.rep[k] = v[k];
                    end
                end
                if (len_keep == '0) begin
                    ev      = finish_event(new_op);
                    n_phase = PH_WAIT;
                    n_count = 4'd0;
                    if (ev[2:0] == wsfr_pkg::K_DONE) begin
                        cmd.length = LW'(len_keep);
                    end
                end
            end
        end
        cmd.ev_valid = ev[3];
        cmd.ev_kind  = ev[2:0];
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.has_byte || cmd.ev_valid || cmd.rep_cnt != '0);

    // Advance frame state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_count <= 4'd0;
            r_left  <= '0;
            r_total <= '0;
            r_op    <= 4'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_left  <= n_left;
            r_total <= n_total;
            r_op    <= n_op;
        end
    end

    // Hold header bytes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STORE_KEEP; k++) begin
            if (accept && !in_payload && idx == 4'(k)) begin
                r_store[k] <= i_byte;
            end
        end
    end

endmodule

[hw/rtl/wsfr_queue.sv]
// Short command queue between the front and back parts of the frame receiver.
// Depends on wsfr_pkg for the command type.
module wsfr_queue #(
    parameter int DEPTH = wsfr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wsfr_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output wsfr_pkg::t_cmd  o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    wsfr_pkg::t_cmd  r_mem [0:DEPTH-1];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/wsfr_back.sv]
// Back part of the frame receiver: expands each queued command into result beats
// (reply bytes, payload byte, end-of-frame event) and holds them in an output register.
// Depends on wsfr_pkg.
module wsfr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    input  wsfr_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [wsfr_pkg::KIND_W-1:0]         o_kind,
    output logic [wsfr_pkg::BYTE_W-1:0]         o_byte,
    output logic [wsfr_pkg::OPC_W-1:0]          o_opcode,
    output logic [wsfr_pkg::FRAME_LEN_W-1:0]    o_length,
    output logic                                o_last
);

    logic [3:0]                         r_pos;
    logic                               r_valid;
    logic [wsfr_pkg::KIND_W-1:0]        r_kind;
    logic [wsfr_pkg::BYTE_W-1:0]        r_byte;
    logic [wsfr_pkg::OPC_W-1:0]         r_opcode;
    logic [wsfr_pkg::FRAME_LEN_W-1:0]   r_length;
    logic                               r_last;

    logic                               load;
    logic [3:0]                         total;
    logic                               is_last;
    logic [wsfr_pkg::KIND_W-1:0]        n_kind;
    logic [wsfr_pkg::BYTE_W-1:0]        n_byte;
    logic [wsfr_pkg::FRAME_LEN_W-1:0]   n_length;

    assign load    = i_cmd_valid && (!r_valid || i_ready);
    assign total   = i_cmd.rep_cnt + 4'(i_cmd.has_byte) + 4'(i_cmd.ev_valid);
    assign is_last = (r_pos + 4'd1 == total);
    assign o_pop   = load && is_last;

    // Pick the beat at the current position of the command
    always_comb begin
        n_kind   = i_cmd.ev_kind;
        n_byte   = '0;
        n_length = i_cmd.length;
        if (r_pos < i_cmd.rep_cnt) begin
            n_kind   = wsfr_pkg::K_REPLY;
            n_byte   = i_cmd.rep[r_pos];
            n_length = '0;
        end else if (r_pos == i_cmd.rep_cnt && i_cmd.has_byte) begin
            n_kind   = i_cmd.byte_kind;
            n_byte   = i_cmd.pay_byte;
            n_length = '0;
        end
    end

    // Step through the command and hold the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos   <= is_last ? 4'd0 : r_pos + 4'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_opcode <= i_cmd.opcode;
            r_length <= n_length;
            r_last   <= is_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_byte   = r_byte;
    assign o_opcode = r_opcode;
    assign o_length = r_length;
    assign o_last   = r_last;

endmodule

[tb/tb_websocket_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_receiver_unit: byte stream in, result beats out.
// Depends on wsfr_pkg and the RTL of the block; it reads no files.
module tb_websocket_frame_receiver_unit;

    // Frame opcodes and length codes of the wire format
    localparam logic [3:0] OPC_CONT  = 4'h0;
    localparam logic [3:0] OPC_BIN   = 4'h2;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;
    localparam logic [3:0] OPC_PONG  = 4'ha;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam int HDR_DEPTH = 14;

    localparam int LEN_BITS = wsfr_pkg::DEF_LENGTH_BITS;
    localparam logic [63:0] LEN_KEEP =
        (LEN_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LEN_BITS) - 64'd1);
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_BYTES = 15;

    typedef enum logic [1:0] {RX_WAIT, RX_HEADER, RX_PAYLOAD} t_rx_phase;
    typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} t_len_form;

    typedef struct packed {
        logic [wsfr_pkg::KIND_W-1:0]      kind;
        logic [wsfr_pkg::BYTE_W-1:0]      data;
        logic [wsfr_pkg::OPC_W-1:0]       opc;
        logic [wsfr_pkg::FRAME_LEN_W-1:0] len;
        logic                             last;
    } t_ws_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [7:0] out_byte, [11:8] frame_opcode, [74:12] frame_length, [79:75] zero
    logic [wsfr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [2:0]            o_m_axis_tuser;           // [2:0] kind
    logic                  o_m_axis_tlast;

    // Deframer state as the checker sees it
    t_rx_phase   rx_phase = RX_WAIT;
    logic [7:0]  hdr_bytes [HDR_DEPTH];
    logic [3:0]  hdr_cnt = '0;
    logic [63:0] pay_left = '0;
    logic [63:0] frame_len = '0;
    logic [3:0]  frame_opc = '0;

    t_ws_result pending_results [$];
    t_ws_result step_results [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int bytes_sent = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    websocket_frame_receiver_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Queue one result of the current input byte
    function automatic void add_result(input logic [2:0] kind, input logic [7:0] data,
                                       input logic [62:0] len);
        t_ws_result r;
        r.kind = kind;
        r.data = data;
        r.opc  = frame_opc;
        r.len  = len;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic int ext_len_bytes();
        if (hdr_bytes[1][6:0] == LEN7_EXT16) return 2;
        if (hdr_bytes[1][6:0] == LEN7_EXT64) return 8;
        return 0;
    endfunction

    // Raise the end-of-frame event for the opcode and go back to header hunting
    function automatic void close_frame();
        if (frame_opc <= OPC_BIN) add_result(wsfr_pkg::K_DONE, 8'h00, frame_len[62:0]);
        else if (frame_opc == OPC_PING) add_result(wsfr_pkg::K_PING, 8'h00, '0);
        else if (frame_opc == OPC_PONG) add_result(wsfr_pkg::K_PONG, 8'h00, '0);
        else if (frame_opc == OPC_CLOSE) add_result(wsfr_pkg::K_CLOSE, 8'h00, '0);
        rx_phase = RX_WAIT;
        hdr_cnt = '0;
    endfunction

    // Advance the deframer by one accepted byte and store what it must emit
    function automatic void predict_byte(input logic [7:0] b);
        int ext;
        int need;
        logic [63:0] len;
        logic [7:0] b0;
        step_results.delete();
        if (rx_phase == RX_PAYLOAD) begin
            if (frame_opc <= OPC_BIN) add_result(wsfr_pkg::K_APP, b, '0);
            else if (frame_opc == OPC_PING || frame_opc == OPC_CLOSE)
                add_result(wsfr_pkg::K_REPLY, b, '0);
            if (pay_left != 0) pay_left = pay_left - 1;
            if (pay_left == 0) close_frame();
        end else begin
            if (rx_phase != RX_HEADER || hdr_cnt >= HDR_DEPTH) hdr_cnt = '0;
            rx_phase = RX_HEADER;
            hdr_bytes[hdr_cnt] = b;
            hdr_cnt = hdr_cnt + 4'd1;
            if (hdr_cnt >= 2) begin
                ext = ext_len_bytes();
                need = 2 + ext + (hdr_bytes[1][7] ? 4 : 0);
                if (hdr_cnt == need) begin
                    // Header complete: decode length, echo ping and close headers
                    len = (ext == 0) ? {57'd0, hdr_bytes[1][6:0]} : 64'd0;
                    for (int i = 0; i < ext; i++) len = {len[55:0], hdr_bytes[2 + i]};
                    len = len & LEN_KEEP;
                    len[63] = 1'b0;
                    frame_len = len;
                    pay_left = len;
                    frame_opc = hdr_bytes[0][3:0];
                    if (frame_opc == OPC_PING || frame_opc == OPC_CLOSE) begin
                        b0 = hdr_bytes[0];
                        if (frame_opc == OPC_PING) b0[3:0] = OPC_PONG;
                        add_result(wsfr_pkg::K_REPLY, b0, '0);
                        add_result(wsfr_pkg::K_REPLY, {1'b0, hdr_bytes[1][6:0]}, '0);
                        for (int i = 0; i < ext; i++)
                            add_result(wsfr_pkg::K_REPLY, hdr_bytes[2 + i], '0);
                    end
                    if (pay_left == 0) close_frame();
                    else rx_phase = RX_PAYLOAD;
                end
            end
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one byte, idling first at the sender's rate, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(1, 100) <= src_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_byte(b);
        bytes_sent++;
    endtask

    // Hold the sender off until every outstanding result has arrived
    task automatic wait_all_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // One frame: opcode byte, length byte, extended length, mask, payload
    task automatic send_frame(input logic [7:0] b0, input logic masked, input t_len_form form,
                              input logic [62:0] pay_len, input logic top_bit,
                              input int pay_sent);
        send_byte(b0);
        case (form)
            FORM_SHORT: send_byte({masked, pay_len[6:0]});
            FORM_EXT16: begin
                send_byte({masked, LEN7_EXT16});
                send_byte(pay_len[15:8]);
                send_byte(pay_len[7:0]);
            end
            default: begin
                send_byte({masked, LEN7_EXT64});
                send_byte({top_bit, pay_len[62:56]});
                for (int i = 6; i >= 0; i--) send_byte(pay_len[i*8 +: 8]);
            end
        endcase
        if (masked) repeat (4) send_byte(8'($urandom));
        repeat (pay_sent) send_byte(8'($urandom));
    endtask

    // Mostly data frames, some control, some reserved opcodes; short lengths
    task automatic send_random_frame();
        int pick;
        int n;
        logic [3:0] op;
        t_len_form form;
        pick = $urandom_range(0, 99);
        if (pick < 55) op = 4'($urandom_range(OPC_CONT, OPC_BIN));
        else if (pick < 65) op = OPC_PING;
        else if (pick < 75) op = OPC_CLOSE;
        else if (pick < 85) op = OPC_PONG;
        else begin
            do op = 4'($urandom);
            while (op <= OPC_BIN || (op >= OPC_CLOSE && op <= OPC_PONG));
        end
        pick = $urandom_range(0, 99);
        form = (pick < 70) ? FORM_SHORT : (pick < 85) ? FORM_EXT16 : FORM_EXT64;
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        send_frame({4'($urandom), op}, 1'($urandom), form, 63'(n), 1'($urandom), n);
    endtask

    // Empty text frame with FIN and all reserved bits set
    task automatic test_empty_frame_reserved_bits();
        send_frame({4'hf, 4'h1}, 1'b0, FORM_SHORT, '0, 1'b0, 0);
    endtask

    // Ping with an all-zero 64-bit length: the longest reply burst
    task automatic test_ping_max_reply();
        send_frame({4'h8, OPC_PING}, 1'b0, FORM_EXT64, '0, 1'b0, 0);
    endtask

    // Binary frame without FIN whose 64-bit length has the top bit set
    task automatic test_length_top_bit_ignored();
        send_frame({4'h0, OPC_BIN}, 1'b0, FORM_EXT64, 63'd1, 1'b1, 1);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        int start;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) send_random_frame();
        wait_all_results();
    endtask

    // Largest length, masked: payload bytes flow but the frame never ends
    task automatic test_unterminated_long_frame();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_frame({4'h8, OPC_BIN}, 1'b1, FORM_EXT64, {63{1'b1}}, 1'b1, 6);
    endtask

    // Randomise the sink's ready line
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(1, 100) > sink_stall_pct);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_ws_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result kind", 64'(o_m_axis_tuser), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser != want.kind)
                    report_mismatch("kind", 64'(o_m_axis_tuser), 64'(want.kind));
                if (o_m_axis_tdata[7:0] != want.data)
                    report_mismatch("out_byte", 64'(o_m_axis_tdata[7:0]), 64'(want.data));
                if (o_m_axis_tdata[11:8] != want.opc)
                    report_mismatch("frame_opcode", 64'(o_m_axis_tdata[11:8]), 64'(want.opc));
                if (o_m_axis_tdata[74:12] != want.len)
                    report_mismatch("frame_length", 64'(o_m_axis_tdata[74:12]), 64'(want.len));
                if (o_m_axis_tlast != want.last)
                    report_mismatch("last", 64'(o_m_axis_tlast), 64'(want.last));
            end
        end
    end

    // End the run when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_frame_reserved_bits();
        test_ping_max_reply();
        test_length_top_bit_ignored();
        wait_all_results();

        test_random_traffic(0, 0);
        test_random_traffic(83, 0);
        test_random_traffic(0, 83);
        test_random_traffic(38, 38);
        test_unterminated_long_frame();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wsfr_pkg.sv
hw/rtl/wsfr_front.sv
hw/rtl/wsfr_queue.sv
hw/rtl/wsfr_back.sv
hw/rtl/websocket_frame_receiver_unit.sv
tb/tb_websocket_frame_receiver_unit.sv
